>>> rtl/llsm_pkg.sv
// Shared types, register indexes and helpers for the line literal matcher.
// No dependencies; used by every module of the block.
`default_nettype none
package llsm_pkg;

  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned PAT_LEN_W   = 6;
  localparam int unsigned PAT_BYTES   = 32;
  localparam int unsigned PAT_IDX_W   = 5;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] line_offset;
    logic [CNT_W-1:0] line_length;
  } rsp_t;

  // shift: a non-newline byte enters the window; clear: the line ends
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_SAT) ? CNT_SAT : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> rtl/llsm_cell.sv
// One window cell: holds a recent byte of the line and its in-line flag.
// Depends on llsm_pkg.
`default_nettype none
module llsm_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire llsm_pkg::cell_ctrl_t  ctrl,
  input  wire logic [7:0]            byte_in,
  input  wire logic                  valid_in,
  input  wire logic [7:0]            ref_byte,
  input  wire logic                  active,
  output logic [7:0]                 byte_out,
  output logic                       valid_out,
  output logic                       match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctrl.clear) begin
      valid_out <= 1'b0;
    end else if (ctrl.shift) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_out <= byte_in;
    end
  end

  // compare against the byte about to land here
  assign match = !active || (valid_in && (byte_in == ref_byte));

endmodule
`default_nettype wire

>>> rtl/llsm_rsp_buf.sv
// Two-entry result buffer between the matcher and the result channel.
// Depends on llsm_pkg.
`default_nettype none
module llsm_rsp_buf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire llsm_pkg::rsp_t push_data,
  output logic                full,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output llsm_pkg::rsp_t      rsp_data
);

  llsm_pkg::rsp_t entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = rsp_valid && !rsp_stall;
  assign rsp_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign rsp_data  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/line_literal_substring_matcher_unit.sv
// Line literal matcher top level: pattern registers, cell chain, line counters.
// Depends on llsm_pkg, llsm_cell and llsm_rsp_buf.
// Throughput: one byte per cycle while the two-entry result buffer is not full; a
// matching line's result is pushed there when its ending byte (newline or last byte)
// is accepted. A config write holds off requests in the next cycle, while the aligned pattern loads.
// Reset (rst, synchronous) clears pattern to zero, length to one, all line state.
`default_nettype none
module line_literal_substring_matcher_unit #(
  parameter int unsigned PATTERN_MAX_BYTES = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               req_valid,
  output logic                                    req_stall,
  input  wire llsm_pkg::req_t                     req_data,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_stall,
  output llsm_pkg::rsp_t                          rsp_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [llsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [llsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned N = PATTERN_MAX_BYTES;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]                     pattern [llsm_pkg::PAT_BYTES];
  logic [llsm_pkg::PAT_LEN_W-1:0] pattern_length;
  logic                           cfg_settle;
  logic                           cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < llsm_pkg::PAT_BYTES; w++) begin
        pattern[w] <= 8'h00;
      end
      pattern_length <= llsm_pkg::PAT_LEN_W'(1);
      cfg_settle     <= 1'b0;
    end else begin
      cfg_settle <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          llsm_pkg::REG_PATTERN_WORD_0,
          llsm_pkg::REG_PATTERN_WORD_1,
          llsm_pkg::REG_PATTERN_WORD_2,
          llsm_pkg::REG_PATTERN_WORD_3: begin
            for (int k = 0; k < 8; k++) begin
              pattern[{cfg_index[1:0], 3'(k)}] <= cfg_data[8*k +: 8];
            end
          end
          llsm_pkg::REG_PATTERN_LENGTH: begin
            pattern_length <= cfg_data[llsm_pkg::PAT_LEN_W-1:0];
          end
          default: begin
            // indexes past the register list are ignored
          end
        endcase
      end
    end
  end

  // Length in use: zero acts as one, anything above the cell count as the count.
  logic [llsm_pkg::PAT_LEN_W-1:0] used_len;

  always_comb begin
    if (pattern_length == '0) begin
      used_len = llsm_pkg::PAT_LEN_W'(1);
    end else if (pattern_length > llsm_pkg::PAT_LEN_W'(N)) begin
      used_len = llsm_pkg::PAT_LEN_W'(N);
    end else begin
      used_len = pattern_length;
    end
  end

  // Cell i compares against the pattern byte at used_len-1-i, so the newest byte
  // lines up with the pattern's last byte. Registered from the pattern and length registers.
  logic [7:0] aligned      [N];
  logic [7:0] aligned_next [N];
  logic [N-1:0] active;
  logic [N-1:0] active_next;

  always_comb begin
    logic [llsm_pkg::PAT_LEN_W-1:0] k;
    for (int i = 0; i < N; i++) begin
      k = used_len - llsm_pkg::PAT_LEN_W'(i) - llsm_pkg::PAT_LEN_W'(1);
      active_next[i]  = llsm_pkg::PAT_LEN_W'(i) < used_len;
      aligned_next[i] = active_next[i] ? pattern[k[llsm_pkg::PAT_IDX_W-1:0]] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= N'(1);
      for (int i = 0; i < N; i++) begin
        aligned[i] <= 8'h00;
      end
    end else begin
      active <= active_next;
      for (int i = 0; i < N; i++) begin
        aligned[i] <= aligned_next[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  logic buf_full;
  logic accept;
  logic is_nl;
  logic line_end;

  assign req_stall = cfg_settle || buf_full;
  assign accept    = req_valid && !req_stall;
  assign is_nl     = (req_data.data_byte == llsm_pkg::NEWLINE_BYTE);
  assign line_end  = is_nl || req_data.is_last;

  // ---------------------------------------------------------------------------
  // Cell chain: bytes and in-line flags march one cell per accepted byte.
  // A newline or the file's last byte empties the window.
  // ---------------------------------------------------------------------------
  llsm_pkg::cell_ctrl_t cell_ctrl;
  logic [7:0]   chain_byte  [N];
  logic [N-1:0] chain_valid;
  logic [N-1:0] cell_match;

  assign cell_ctrl.shift = accept && !line_end;
  assign cell_ctrl.clear = accept && line_end;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [7:0] byte_in;
    logic       valid_in;
    if (i == 0) begin : g_head
      assign byte_in  = req_data.data_byte;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign byte_in  = chain_byte[i-1];
      assign valid_in = chain_valid[i-1];
    end
    llsm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .byte_in   (byte_in),
      .valid_in  (valid_in),
      .ref_byte  (aligned[i]),
      .active    (active[i]),
      .byte_out  (chain_byte[i]),
      .valid_out (chain_valid[i]),
      .match     (cell_match[i])
    );
  end

  // Window after this byte matches; a newline never joins a match.
  logic hit_now;
  assign hit_now = !is_nl && (&cell_match);

  // ---------------------------------------------------------------------------
  // Line counters (all saturating)
  // ---------------------------------------------------------------------------
  logic                       line_hit;
  logic [llsm_pkg::CNT_W-1:0] bytes_in_line;
  logic [llsm_pkg::CNT_W-1:0] line_count;
  logic [llsm_pkg::CNT_W-1:0] line_start;
  logic [llsm_pkg::CNT_W-1:0] file_position;
  logic                       line_hit_next;
  logic [llsm_pkg::CNT_W-1:0] bytes_in_line_next;
  logic [llsm_pkg::CNT_W-1:0] file_position_next;
  logic                       emit;
  llsm_pkg::rsp_t             emit_data;

  assign line_hit_next      = line_hit || hit_now;
  assign bytes_in_line_next = is_nl ? bytes_in_line : llsm_pkg::sat_inc(bytes_in_line);
  assign file_position_next = llsm_pkg::sat_inc(file_position);

  assign emit                  = accept && line_end && line_hit_next;
  assign emit_data.line_number = line_count;
  assign emit_data.line_offset = line_start;
  assign emit_data.line_length = bytes_in_line_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_hit      <= 1'b0;
      bytes_in_line <= '0;
      line_count    <= llsm_pkg::CNT_W'(1);
      line_start    <= '0;
      file_position <= '0;
    end else if (accept) begin
      if (req_data.is_last) begin
        // end of file: fresh state for the next one
        line_hit      <= 1'b0;
        bytes_in_line <= '0;
        line_count    <= llsm_pkg::CNT_W'(1);
        line_start    <= '0;
        file_position <= '0;
      end else if (is_nl) begin
        line_hit      <= 1'b0;
        bytes_in_line <= '0;
        line_count    <= llsm_pkg::sat_inc(line_count);
        line_start    <= file_position_next;
        file_position <= file_position_next;
      end else begin
        line_hit      <= line_hit_next;
        bytes_in_line <= bytes_in_line_next;
        file_position <= file_position_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: keeps taking bytes while one result waits downstream.
  // ---------------------------------------------------------------------------
  llsm_rsp_buf u_rsp_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (emit_data),
    .full      (buf_full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // no result is produced into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    emit |-> !buf_full)
    else $error("result pushed into full buffer");

  // end of file returns counters to their start values
  a_file_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && req_data.is_last) |=> (line_count == llsm_pkg::CNT_W'(1) &&
      file_position == '0 && bytes_in_line == '0 && !line_hit))
    else $error("state not cleared after last byte");

  // request held off in the cycle after a config write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> req_stall)
    else $error("request accepted while pattern reloads");

  // a reported line always holds at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.line_length != '0))
    else $error("empty line reported as a match");

endmodule
`default_nettype wire

>>> bench/line_literal_substring_matcher_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for line_literal_substring_matcher_unit. It streams small files one byte at a
// time, predicts each matching-line report in the bench and checks the reports in order.
// Depends on llsm_pkg and the matcher RTL; it needs no other file.
module line_literal_substring_matcher_unit_tb;

  localparam int unsigned SETTLE_CYCLES = 8;       // result latency plus the two-entry buffer
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned WATCHDOG_NS   = 5_000_000;
  localparam int unsigned PHASE_BYTES   = 580;
  // indexes past the register list; writes there must change nothing
  localparam logic [llsm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LOW  = 3'd5;
  localparam logic [llsm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HIGH = 3'd7;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  llsm_pkg::req_t                  req_data  = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  llsm_pkg::rsp_t                  rsp_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [llsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [llsm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned fail_count    = 0;

  // bench copy of the configuration
  logic [63:0]                    pat_word [4];
  logic [llsm_pkg::PAT_LEN_W-1:0] pat_len;

  // bench copy of the line state
  logic [7:0]                 line_tail [llsm_pkg::PAT_BYTES];   // newest byte at entry 0
  logic [llsm_pkg::CNT_W-1:0] line_bytes;
  logic [llsm_pkg::CNT_W-1:0] line_num;
  logic [llsm_pkg::CNT_W-1:0] line_begin;
  logic [llsm_pkg::CNT_W-1:0] file_pos;
  logic                       line_matched;

  llsm_pkg::rsp_t pending_hits [$];   // line reports still owed by the block, oldest first
  logic [7:0]     file_buf [$];

  line_literal_substring_matcher_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver stall: redrawn every falling edge. It is low throughout the no-idle phase.
  always @(negedge clk) begin
    rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [llsm_pkg::CNT_W-1:0] bump(input logic [llsm_pkg::CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;   // counters stick at all ones
  endfunction

  // A length of zero behaves as one; anything past the window behaves as the full window.
  function automatic int unsigned active_len();
    if (pat_len == 0) return 1;
    if (pat_len > llsm_pkg::PAT_BYTES) return llsm_pkg::PAT_BYTES;
    return pat_len;
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned k);
    return pat_word[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic void clear_line_state();
    foreach (line_tail[i]) line_tail[i] = 8'h00;
    line_bytes   = '0;
    line_matched = 1'b0;
    line_num     = 1;
    line_begin   = '0;
    file_pos     = '0;
  endfunction

  function automatic void reset_model();
    foreach (pat_word[i]) pat_word[i] = '0;
    pat_len = 1;
    clear_line_state();
  endfunction

  function automatic void track_config(input logic [llsm_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [llsm_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      llsm_pkg::REG_PATTERN_WORD_0: pat_word[0] = val;
      llsm_pkg::REG_PATTERN_WORD_1: pat_word[1] = val;
      llsm_pkg::REG_PATTERN_WORD_2: pat_word[2] = val;
      llsm_pkg::REG_PATTERN_WORD_3: pat_word[3] = val;
      llsm_pkg::REG_PATTERN_LENGTH: pat_len = val[llsm_pkg::PAT_LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Advances the line state by one accepted byte and queues the report it causes, if any.
  function automatic void track_byte(input logic [7:0] b, input logic last);
    int unsigned    len;
    logic           hit;
    llsm_pkg::rsp_t rpt;
    len = active_len();
    if (b != llsm_pkg::NEWLINE_BYTE) begin
      for (int i = llsm_pkg::PAT_BYTES - 1; i > 0; i--) line_tail[i] = line_tail[i-1];
      line_tail[0] = b;
      line_bytes   = bump(line_bytes);
      // the window only counts once the line holds enough bytes of its own
      if (line_bytes >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (line_tail[i] != pat_byte(len - 1 - i)) hit = 1'b0;
        if (hit) line_matched = 1'b1;
      end
    end
    file_pos = bump(file_pos);
    if (b == llsm_pkg::NEWLINE_BYTE || last) begin
      if (line_matched) begin
        rpt.line_number = line_num;
        rpt.line_offset = line_begin;
        rpt.line_length = line_bytes;
        pending_hits = {pending_hits, rpt};
      end
      if (last) begin
        clear_line_state();   // next file starts at line 1, offset 0
      end else begin
        line_num     = bump(line_num);
        line_begin   = file_pos;
        line_bytes   = '0;
        line_matched = 1'b0;
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void flag_mismatch(input string what,
                                        input logic [llsm_pkg::CNT_W-1:0] want,
                                        input logic [llsm_pkg::CNT_W-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  // Every report taken by the receiver is held against the oldest owed one.
  always @(posedge clk) begin : check_reports
    llsm_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_hits.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected report, expected none, actual line %0d offset %0d length %0d",
                 $time, rsp_data.line_number, rsp_data.line_offset, rsp_data.line_length);
      end else begin
        want = pending_hits.pop_front();
        if (want.line_number !== rsp_data.line_number)
          flag_mismatch("line_number", want.line_number, rsp_data.line_number);
        if (want.line_offset !== rsp_data.line_offset)
          flag_mismatch("line_offset", want.line_offset, rsp_data.line_offset);
        if (want.line_length !== rsp_data.line_length)
          flag_mismatch("line_length", want.line_length, rsp_data.line_length);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Entered and left at a falling edge. Valid stays high on return so that the next
  // request can follow back to back; settle() drops it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    llsm_pkg::req_t item;
    item.data_byte = b;
    item.is_last   = last;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    track_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit ends_file);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], ends_file && (i == s.len() - 1));
  endtask

  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++)
      send_byte(file_buf[i], i == file_buf.size() - 1);
  endtask

  // Quiet the request side, wait out every owed report, then let the pipe go idle.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    req_valid <= 1'b0;
    while (pending_hits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_hits.size() != 0) begin
      $display("%0t: %0d expected reports never arrived, expected line %0d, actual none",
               $time, pending_hits.size(), pending_hits[0].line_number);
      fail_count++;
      pending_hits.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high so consecutive writes go back to back; set_pattern drops it.
  task automatic write_reg(input logic [llsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [llsm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    track_config(idx, val);
    @(negedge clk);
  endtask

  // Pattern byte k sits at bits 8k of the 256-bit vector, same as the register layout.
  // Upper bits of the length write carry junk; only the low six bits count.
  task automatic set_pattern(input logic [255:0] bytes,
                             input logic [llsm_pkg::PAT_LEN_W-1:0] len,
                             input bit words_too);
    logic [llsm_pkg::CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[llsm_pkg::PAT_LEN_W-1:0] = len;
    if (words_too) begin
      write_reg(llsm_pkg::REG_PATTERN_WORD_0, bytes[63:0]);
      write_reg(llsm_pkg::REG_PATTERN_WORD_1, bytes[127:64]);
      write_reg(llsm_pkg::REG_PATTERN_WORD_2, bytes[191:128]);
      write_reg(llsm_pkg::REG_PATTERN_WORD_3, bytes[255:192]);
    end
    write_reg(llsm_pkg::REG_PATTERN_LENGTH, len_word);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus shaping

  // Mostly pattern bytes so near misses are common, some small letters, a few wild bytes.
  function automatic logic [7:0] filler_byte();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 6) return pat_byte($urandom_range(active_len() - 1));
    if (roll < 9) return 8'(8'h61 + $urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // A few lines; each gets the pattern whole, cut short by one byte, or not at all.
  // A noisy file is raw random bytes.
  task automatic build_file(input bit noisy);
    int unsigned len, n_lines, line_len, spot, cut, embed;
    file_buf.delete();
    len     = active_len();
    n_lines = $urandom_range(1, 5);
    for (int l = 0; l < n_lines; l++) begin
      line_len = $urandom_range(0, 12);
      cut      = $urandom_range(2);
      embed    = (cut == 1 && len > 1) ? len - 1 : len;
      spot     = (!noisy && cut != 0) ? $urandom_range(0, line_len) : line_len + 1;
      for (int i = 0; i <= line_len; i++) begin
        if (i == spot)
          for (int k = 0; k < embed; k++) file_buf = {file_buf, pat_byte(k)};
        if (i < line_len)
          file_buf = {file_buf, (noisy ? 8'($urandom_range(255)) : filler_byte())};
      end
      // the final line ends either at a newline or at the bare last byte
      if (l + 1 < n_lines || $urandom_range(1))
        file_buf = {file_buf, llsm_pkg::NEWLINE_BYTE};
    end
    if (file_buf.size() == 0) file_buf = {file_buf, filler_byte()};
  endtask

  task automatic random_pattern();
    logic [255:0]                   bytes;
    logic [llsm_pkg::PAT_LEN_W-1:0] len;
    bit                             wide;
    int unsigned                    roll;
    wide = ($urandom_range(4) == 0);
    for (int k = 0; k < llsm_pkg::PAT_BYTES; k++)
      bytes[8*k +: 8] = wide ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(3));
    roll = $urandom_range(9);
    case (roll)
      0:       len = 1;
      1:       len = llsm_pkg::PAT_BYTES;
      2:       len = 0;
      3:       len = llsm_pkg::PAT_LEN_W'($urandom_range(llsm_pkg::PAT_BYTES + 1, 63));
      default: len = llsm_pkg::PAT_LEN_W'($urandom_range(2, 6));
    endcase
    settle();
    set_pattern(bytes, len, $urandom_range(3) != 0);
  endtask

  // ---------------------------------------------------------------- tests

  // Reset pattern is one zero byte.
  task automatic test_reset_pattern();
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(llsm_pkg::NEWLINE_BYTE, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Empty lines, a match on a later line, the last line without a newline, no match
  // across a newline, and a newline as the final byte with no empty line after it.
  task automatic test_line_boundaries();
    settle();
    set_pattern({64'hFFFF_FFFF_FFFF_FFFF, 128'h0, 64'h6261}, 6'd2, 1'b1);
    send_text("ab\n\nxab", 1'b1);
    send_text("a\nb", 1'b1);
    send_text("zab\n", 1'b1);
  endtask

  // A pattern holding a newline never hits; writes past the register list are dropped.
  task automatic test_newline_pattern();
    settle();
    write_reg(REG_UNMAPPED_LOW, {llsm_pkg::CFG_DATA_W{1'b1}});
    write_reg(REG_UNMAPPED_HIGH, {llsm_pkg::CFG_DATA_W{1'b1}});
    set_pattern(256'h62_0A_61, 6'd3, 1'b1);
    send_text("a\nb", 1'b1);
  endtask

  // Length zero acts as one byte: a one-byte file that matches.
  task automatic test_zero_length();
    settle();
    set_pattern(256'hFF, 6'd0, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + PHASE_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(3) == 0) random_pattern();
      build_file($urandom_range(4) == 0);
      send_file();
    end
  endtask

  initial begin
    reset_model();
    send_idle_pct = 32;
    recv_idle_pct = 64;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_pattern();
    test_line_boundaries();
    test_newline_pattern();
    test_zero_length();
    test_random_phase(32, 64);
    test_random_phase(64, 32);
    test_random_phase(0, 0);
    settle();

    if (fail_count == 0)
      $display("PASS line_literal_substring_matcher_unit");
    else
      $display("FAIL line_literal_substring_matcher_unit");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(WATCHDOG_NS);
    $display("FAIL line_literal_substring_matcher_unit");
    $finish;
  end

endmodule

>>> filelist.f
rtl/llsm_pkg.sv
rtl/llsm_cell.sv
rtl/llsm_rsp_buf.sv
rtl/line_literal_substring_matcher_unit.sv
bench/line_literal_substring_matcher_unit_tb.sv
